### rtl/core/assert_macros.svh
// Assertion macros shared by the deduplicator RTL.
// Needs clk_i and rst_ni in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ITD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// Antecedent on one edge implies consequent on the next.
`define ITD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/core/itd_pkg.sv
// Package for the index tuple deduplicator: sizes, widths and FSM type.
// No dependencies.
`default_nettype none

package itd_pkg;

  localparam int MaxTupleWords = 4;
  localparam int TableDepth    = 1024;
  localparam int InputWords    = 4;
  localparam int WordW         = 32;
  localparam int KeyW          = MaxTupleWords * WordW;
  localparam int IdxW          = 10;
  localparam int AddrW         = $clog2(TableDepth);
  localparam int CntW          = $clog2(TableDepth + 1);
  localparam int CfgW          = 3;
  localparam int WidthW        = $clog2(MaxTupleWords + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } itd_state_e;

endpackage

`default_nettype wire

### rtl/core/itd_if.sv
// Channel interfaces of the deduplicator: input tuples, results, config writes.
// Depends on itd_pkg.
`default_nettype none

interface itd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     restart;
  logic [itd_pkg::WordW-1:0] word_0;
  logic [itd_pkg::WordW-1:0] word_1;
  logic [itd_pkg::WordW-1:0] word_2;
  logic [itd_pkg::WordW-1:0] word_3;

  modport source (output valid, restart, word_0, word_1, word_2, word_3, input ready);
  modport sink   (input valid, restart, word_0, word_1, word_2, word_3, output ready);
endinterface

interface itd_out_if;
  logic                     valid;
  logic                     ready;
  logic [itd_pkg::IdxW-1:0]  combined_index;
  logic                     is_new;
  logic                     overflow;
  logic [itd_pkg::WordW-1:0] echo_0;
  logic [itd_pkg::WordW-1:0] echo_1;
  logic [itd_pkg::WordW-1:0] echo_2;
  logic [itd_pkg::WordW-1:0] echo_3;

  modport source (output valid, combined_index, is_new, overflow,
                  echo_0, echo_1, echo_2, echo_3, input ready);
  modport sink   (input valid, combined_index, is_new, overflow,
                  echo_0, echo_1, echo_2, echo_3, output ready);
endinterface

interface itd_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [itd_pkg::CfgW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/core/itd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module itd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/itd_cmp.sv
// Key comparator: matches a stored key against the current key over the
// leading words selected by the tuple width. Depends on itd_pkg.
`default_nettype none

module itd_cmp (
  input  wire logic [itd_pkg::KeyW-1:0]   key_i,
  input  wire logic [itd_pkg::KeyW-1:0]   stored_i,
  input  wire logic [itd_pkg::WidthW-1:0] width_i,
  output logic                            match_o
);

  always_comb begin
    match_o = 1'b1;
    for (int i = 0; i < itd_pkg::MaxTupleWords; i++) begin
      if (i < int'(width_i) &&
          key_i[i*itd_pkg::WordW +: itd_pkg::WordW] !=
          stored_i[i*itd_pkg::WordW +: itd_pkg::WordW]) begin
        match_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/itd_seq.sv
// Scan sequencer: latches a tuple, walks the tuple store one entry a cycle
// through the shared comparator, appends misses and holds the result.
// Depends on itd_pkg, itd_if, itd_ram, itd_cmp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module itd_seq (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [itd_pkg::WidthW-1:0]   width_i,
  itd_in_if.sink                            in_i,
  itd_out_if.source                         res_o
);

  itd_pkg::itd_state_e state_q, state_d;

  logic [itd_pkg::KeyW-1:0]  key_q, key_d;
  logic [itd_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [itd_pkg::CntW-1:0]  raddr_q, raddr_d;
  logic                      cmp_v_q, cmp_v_d;
  logic [itd_pkg::IdxW-1:0]  cmp_idx_q, cmp_idx_d;
  logic [itd_pkg::IdxW-1:0]  res_idx_q, res_idx_d;
  logic                      res_new_q, res_new_d;
  logic                      res_ovf_q, res_ovf_d;
  logic                      out_v_q, out_v_d;
  logic [itd_pkg::IdxW-1:0]  out_idx_q, out_idx_d;
  logic                      out_new_q, out_new_d;
  logic                      out_ovf_q, out_ovf_d;
  logic [itd_pkg::WordW-1:0] out_echo_q [itd_pkg::InputWords];
  logic [itd_pkg::WordW-1:0] out_echo_d [itd_pkg::InputWords];

  logic [itd_pkg::WordW-1:0] in_words [itd_pkg::InputWords];
  logic                      in_acc;
  logic                      issue;
  logic                      ram_we, ram_re;
  logic [itd_pkg::AddrW-1:0] ram_waddr;
  logic [itd_pkg::KeyW-1:0]  ram_rdata;
  logic                      match;

  assign in_words[0] = in_i.word_0;
  assign in_words[1] = in_i.word_1;
  assign in_words[2] = in_i.word_2;
  assign in_words[3] = in_i.word_3;

  assign in_i.ready = (state_q == itd_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign issue      = (state_q == itd_pkg::ST_SCAN) && (raddr_q < cnt_q);
  assign ram_re     = issue;

  itd_ram #(
    .Width (itd_pkg::KeyW),
    .Depth (itd_pkg::TableDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (raddr_q[itd_pkg::AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  itd_cmp u_cmp (
    .key_i    (key_q),
    .stored_i (ram_rdata),
    .width_i  (width_i),
    .match_o  (match)
  );

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    cnt_d     = cnt_q;
    raddr_d   = raddr_q;
    cmp_v_d   = 1'b0;
    cmp_idx_d = raddr_q[itd_pkg::IdxW-1:0];
    res_idx_d = res_idx_q;
    res_new_d = res_new_q;
    res_ovf_d = res_ovf_q;
    out_v_d   = out_v_q && !res_o.ready;
    out_idx_d = out_idx_q;
    out_new_d = out_new_q;
    out_ovf_d = out_ovf_q;
    out_echo_d = out_echo_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q[itd_pkg::AddrW-1:0];

    unique case (state_q)
      itd_pkg::ST_IDLE: begin
        if (in_acc) begin
          // Zero the words beyond the width so stored keys carry zeros there
          key_d = '0;
          for (int i = 0; i < itd_pkg::MaxTupleWords; i++) begin
            if (i < itd_pkg::InputWords && i < int'(width_i)) begin
              key_d[i*itd_pkg::WordW +: itd_pkg::WordW] = in_words[i];
            end
          end
          if (in_i.restart) begin
            cnt_d = '0;
          end
          raddr_d = '0;
          state_d = itd_pkg::ST_SCAN;
        end
      end
      itd_pkg::ST_SCAN: begin
        if (issue) begin
          raddr_d = raddr_q + 1'b1;
          cmp_v_d = 1'b1;
        end
        if (cmp_v_q && match) begin
          res_idx_d = cmp_idx_q;
          res_new_d = 1'b0;
          res_ovf_d = 1'b0;
          cmp_v_d   = 1'b0;
          state_d   = itd_pkg::ST_DONE;
        end else if (!issue) begin
          // Every entry compared without a hit: append or report overflow
          if (cnt_q < itd_pkg::CntW'(itd_pkg::TableDepth)) begin
            ram_we    = 1'b1;
            res_idx_d = cnt_q[itd_pkg::IdxW-1:0];
            res_new_d = 1'b1;
            res_ovf_d = 1'b0;
            cnt_d     = cnt_q + 1'b1;
          end else begin
            res_idx_d = '0;
            res_new_d = 1'b0;
            res_ovf_d = 1'b1;
          end
          state_d = itd_pkg::ST_DONE;
        end
      end
      itd_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_v_q || res_o.ready) begin
          out_v_d   = 1'b1;
          out_idx_d = res_idx_q;
          out_new_d = res_new_q;
          out_ovf_d = res_ovf_q;
          for (int k = 0; k < itd_pkg::InputWords; k++) begin
            out_echo_d[k] = (k < itd_pkg::MaxTupleWords) ?
                            key_q[k*itd_pkg::WordW +: itd_pkg::WordW] : '0;
          end
          state_d = itd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = itd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itd_pkg::ST_IDLE;
      cnt_q   <= '0;
      raddr_q <= '0;
      cmp_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      raddr_q <= raddr_d;
      cmp_v_q <= cmp_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    cmp_idx_q  <= cmp_idx_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_ovf_q  <= res_ovf_d;
    out_idx_q  <= out_idx_d;
    out_new_q  <= out_new_d;
    out_ovf_q  <= out_ovf_d;
    out_echo_q <= out_echo_d;
  end

  assign res_o.valid          = out_v_q;
  assign res_o.combined_index = out_idx_q;
  assign res_o.is_new         = out_new_q;
  assign res_o.overflow       = out_ovf_q;
  assign res_o.echo_0         = out_echo_q[0];
  assign res_o.echo_1         = out_echo_q[1];
  assign res_o.echo_2         = out_echo_q[2];
  assign res_o.echo_3         = out_echo_q[3];

  `ITD_ASSERT(a_cnt_bound, cnt_q <= itd_pkg::CntW'(itd_pkg::TableDepth))
  `ITD_ASSERT(a_scan_bound, (state_q != itd_pkg::ST_SCAN) || (raddr_q <= cnt_q))
  `ITD_ASSERT_NEXT(a_append_count, ram_we, cnt_q == $past(cnt_q) + 1'b1)
  `ITD_ASSERT(a_flags_excl, !(out_v_q && out_new_q && out_ovf_q))

endmodule

`default_nettype wire

### rtl/core/index_tuple_deduplicator_core.sv
// Index tuple deduplicator. Each input transaction carries up to four 32-bit
// words; the first tuple_width of them form a key. Keys are numbered 0, 1, 2...
// in order of first appearance and kept in a 1024-entry store; a result gives
// the key's number, flags a first sighting (is_new) or a full table (overflow,
// index 0) and echoes the key words, zero beyond the width. restart empties
// the table before its own tuple is looked up. The store is searched linearly
// through its single read port, one entry per cycle. The result becomes valid
// in the same cycle as the next transaction can be taken. A result still
// waiting at the output holds the sequencer for as long as the receiver
// stalls. No clearing pass is needed after reset. tuple_width 0 acts as 1,
// values above 4 as 4.
// Depends on itd_pkg, itd_if and itd_seq.
`default_nettype none

module index_tuple_deduplicator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  itd_in_if.sink    in_i,
  itd_out_if.source res_o,
  itd_cfg_if.sink   cfg_i
);

  logic [itd_pkg::CfgW-1:0]   width_raw_q, width_raw_d;
  logic [itd_pkg::WidthW-1:0] width_eff;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    width_raw_d = width_raw_q;
    if (cfg_i.valid && cfg_i.ready) begin
      width_raw_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_raw_q <= itd_pkg::CfgW'(1);
    end else begin
      width_raw_q <= width_raw_d;
    end
  end

  // Clamp the register to the range the key actually supports
  always_comb begin
    priority if (width_raw_q == '0) begin
      width_eff = itd_pkg::WidthW'(1);
    end else if (int'(width_raw_q) > itd_pkg::MaxTupleWords) begin
      width_eff = itd_pkg::WidthW'(itd_pkg::MaxTupleWords);
    end else begin
      width_eff = itd_pkg::WidthW'(width_raw_q);
    end
  end

  itd_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .width_i (width_eff),
    .in_i    (in_i),
    .res_o   (res_o)
  );

endmodule

`default_nettype wire
